// ===== hdl/srs_pkg.sv =====
// Shared types and codes for the stable descending rank selector.
// No dependencies; imported by srs_ctrl, srs_dpath and the top level.
package srs_pkg;

   localparam int unsigned OP_WIDTH    = 2;
   localparam int unsigned SCORE_WIDTH = 16;
   localparam int unsigned TAG_WIDTH   = 16;
   localparam int unsigned RANK_WIDTH  = 7;

   localparam logic [OP_WIDTH-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_QUERY  = 2'd2;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef struct packed {
      logic [SCORE_WIDTH-1:0] score;
      logic [TAG_WIDTH-1:0]   tag;
   } rec_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic clear;
      logic scan;
      logic qread;
      logic qresp;
      logic reject;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic ins_done;
   } status_type;

endpackage

// ===== hdl/srs_ctrl.sv =====
// Controller state machine of the rank selector.
// Depends on srs_pkg; drives srs_dpath through cmd_type, watches status_type.
module srs_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [srs_pkg::OP_WIDTH-1:0]    req_opcode,
   input  srs_pkg::status_type             status,
   output srs_pkg::cmd_type                cmd,
   output logic                            busy
);
   import srs_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_QREAD  = 3'd2;
   localparam logic [2:0] S_QRESP  = 3'd3;
   localparam logic [2:0] S_REJECT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_APPEND: state_in = status.full ? S_REJECT : S_SCAN;
                  OP_QUERY:  state_in = S_QREAD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (status.ins_done) state_in = S_IDLE;
         end
         S_QREAD:  state_in = S_QRESP;
         S_QRESP:  state_in = S_IDLE;
         S_REJECT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      cmd.accept = accept;
      cmd.clear  = accept && (req_opcode == OP_CLEAR);
      cmd.scan   = (state_ff == S_SCAN);
      cmd.qread  = (state_ff == S_QREAD);
      cmd.qresp  = (state_ff == S_QRESP);
      cmd.reject = (state_ff == S_REJECT);
   end

endmodule

// ===== hdl/srs_dpath.sv =====
// Datapath of the rank selector: record memory, count, insertion scan, result registers.
// Depends on srs_pkg; commanded by srs_ctrl.
module srs_dpath #(
   parameter int unsigned MAX_RECORDS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  srs_pkg::cmd_type                       cmd,
   input  logic signed [srs_pkg::SCORE_WIDTH-1:0] req_score,
   input  logic [srs_pkg::TAG_WIDTH-1:0]          req_tag,
   input  logic [srs_pkg::RANK_WIDTH-1:0]         req_rank,
   output srs_pkg::status_type                    status,
   output logic                                   rsp_strobe,
   output logic                                   rsp_kind,
   output logic                                   rsp_error,
   output logic signed [srs_pkg::SCORE_WIDTH-1:0] rsp_found_score,
   output logic [srs_pkg::TAG_WIDTH-1:0]          rsp_found_tag
);
   import srs_pkg::*;

   localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
   localparam int unsigned W  = (CW > RANK_WIDTH) ? CW : RANK_WIDTH;

   rec_type           mem [MAX_RECORDS];
   rec_type           rdata_ff;
   rec_type           key_ff;
   rec_type           wdata;
   logic [AW-1:0]     raddr;
   logic [AW-1:0]     waddr;
   logic              we;

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     scan_addr_ff, scan_addr_in;
   logic              rvalid_ff, rvalid_in;
   logic [RANK_WIDTH-1:0] rank_ff;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic              rsp_error_ff, rsp_error_in;
   logic [SCORE_WIDTH-1:0] rsp_score_ff, rsp_score_in;
   logic [TAG_WIDTH-1:0]   rsp_tag_ff, rsp_tag_in;

   logic [W-1:0]      rank_ext;
   logic [W-1:0]      count_ext;
   logic [W-1:0]      qaddr;
   logic [CW-1:0]     ptr_dec;
   logic              less;
   logic              issue;
   logic              ins_done;
   logic              rank_bad;

   assign rank_ext  = W'(rank_ff);
   assign count_ext = W'(count_ff);
   assign qaddr     = rank_ext - 1'b1;
   assign ptr_dec   = ptr_ff - 1'b1;

   // stored record moves down one slot when the new score is strictly higher
   assign less     = $signed(rdata_ff.score) < $signed(key_ff.score);
   assign ins_done = cmd.scan && (rvalid_ff ? !less : (ptr_ff == '0));
   assign issue    = cmd.scan && (ptr_ff != '0) && !ins_done;

   assign we    = cmd.scan && (rvalid_ff || (ptr_ff == '0));
   assign waddr = rvalid_ff ? AW'(scan_addr_ff + 1'b1) : '0;
   assign wdata = (rvalid_ff && less) ? rdata_ff : key_ff;
   assign raddr = cmd.qread ? qaddr[AW-1:0] : ptr_dec[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rank_bad = (rank_ext == '0) || (rank_ext > count_ext);

   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      scan_addr_in = scan_addr_ff;
      rvalid_in    = issue;
      if (cmd.clear)      count_in = '0;
      else if (ins_done)  count_in = count_ff + 1'b1;
      if (cmd.accept)     ptr_in = count_ff;
      else if (issue) begin
         ptr_in       = ptr_dec;
         scan_addr_in = ptr_dec[AW-1:0];
      end

      rsp_strobe_in = cmd.qresp || cmd.reject;
      rsp_kind_in   = cmd.reject ? KIND_REJECT : KIND_ANSWER;
      rsp_error_in  = cmd.reject || rank_bad;
      rsp_score_in  = (cmd.reject || rank_bad) ? '0 : rdata_ff.score;
      rsp_tag_in    = (cmd.reject || rank_bad) ? '0 : rdata_ff.tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rvalid_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rvalid_ff     <= rvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      scan_addr_ff <= scan_addr_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_error_ff <= rsp_error_in;
      rsp_score_ff <= rsp_score_in;
      rsp_tag_ff   <= rsp_tag_in;
      if (cmd.accept) begin
         key_ff.score <= req_score;
         key_ff.tag   <= req_tag;
         rank_ff      <= req_rank;
      end
   end

   assign status.full     = (count_ff == CW'(MAX_RECORDS));
   assign status.ins_done = ins_done;

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_error       = rsp_error_ff;
   assign rsp_found_score = rsp_score_ff;
   assign rsp_found_tag   = rsp_tag_ff;

endmodule

// ===== hdl/stable_descending_rank_select.sv =====
// Stable descending rank selector: keeps up to MAX_RECORDS score/tag records
// sorted highest score first, equal scores in arrival order. busy is low only
// when a new transaction can be taken. A clear never raises busy. An append
// holds busy through the SCAN state: the insertion walks the record memory
// (one read and one write port) from the bottom, moving one record down a
// slot per cycle until the new record's place is found. A query holds busy
// through the QREAD and QRESP states and its result shows on rsp_strobe in
// the cycle after QRESP; a rejected append (store full) holds busy through
// the REJECT state and its result follows. Results are never held back: each
// is valid for exactly the one cycle its strobe is high. No memory clearing
// pass is needed after reset.
// Depends on srs_pkg, srs_ctrl and srs_dpath.
module stable_descending_rank_select #(
   parameter int unsigned MAX_RECORDS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [srs_pkg::OP_WIDTH-1:0]           req_opcode,
   input  logic signed [srs_pkg::SCORE_WIDTH-1:0] req_score,
   input  logic [srs_pkg::TAG_WIDTH-1:0]          req_tag,
   input  logic [srs_pkg::RANK_WIDTH-1:0]         req_rank,
   output logic                                   rsp_strobe,
   output logic                                   rsp_kind,
   output logic                                   rsp_error,
   output logic signed [srs_pkg::SCORE_WIDTH-1:0] rsp_found_score,
   output logic [srs_pkg::TAG_WIDTH-1:0]          rsp_found_tag
);
   import srs_pkg::*;

   cmd_type    cmd;
   status_type status;

   srs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   srs_dpath #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_score       (req_score),
      .req_tag         (req_tag),
      .req_rank        (req_rank),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_error       (rsp_error),
      .rsp_found_score (rsp_found_score),
      .rsp_found_tag   (rsp_found_tag)
   );

   // a reject transaction is always an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_kind == KIND_REJECT) |-> rsp_error)
      else $error("reject without error flag");

   // errored results carry no record
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_error |-> (rsp_found_score == '0) && (rsp_found_tag == '0))
      else $error("error result carries data");

   // a result only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without preceding work");

   // the insertion scan never runs into a full store
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> !status.full)
      else $error("insert scan on full store");

endmodule
